// ----- rtl/core/rational_arithmetic_unit_top_defines.svh -----
// Assertion macros for the rational arithmetic unit checker.
`ifndef RATIONAL_ARITHMETIC_UNIT_TOP_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_TOP_DEFINES_SVH
// Property held on every clock edge outside reset.
`define RAU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property checked also during reset.
`define RAU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- rtl/core/rau_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rau_pkg
// Shared widths, operation codes and the command structs for the shared units.
// ----------------------------------------------------------------------------
package rau_pkg;
    localparam int OperandBits = 16;
    localparam int MaxExponent = 3;
    localparam int ResBits     = 47;
    localparam int MagBits     = ResBits - 1;
    localparam int KindBits    = 3;
    localparam int CntBits     = 6;

    typedef enum logic [KindBits-1:0] {
        KIND_ADD = 3'd0,
        KIND_SUB = 3'd1,
        KIND_MUL = 3'd2,
        KIND_DIV = 3'd3,
        KIND_POW = 3'd4
    } t_kind;

    // Command into the shared multiplier.
    typedef struct packed {
        logic                      go;
        logic signed [ResBits-1:0] x;
        logic signed [ResBits-1:0] y;
    } t_mul_cmd;

    // Command into the shared divider.
    typedef struct packed {
        logic               go;
        logic [MagBits-1:0] dividend;
        logic [MagBits-1:0] divisor;
    } t_div_cmd;
endpackage
`default_nettype wire

// ----- rtl/core/rau_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rau_mul
// Shift-add signed multiplier, one bit of y per cycle, 47-bit wrapped result.
// ----------------------------------------------------------------------------
module rau_mul (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire rau_pkg::t_mul_cmd                  i_cmd,
    output logic                                    o_done,
    output logic signed [rau_pkg::ResBits-1:0]      o_prod
);
    logic [rau_pkg::ResBits-1:0] r_acc, r_x, r_y;
    logic [rau_pkg::CntBits-1:0] r_cnt;
    logic                        r_busy, r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && !i_cmd.go &&
                      (r_cnt == rau_pkg::CntBits'(rau_pkg::ResBits - 1));
            if (i_cmd.go) begin
                r_busy <= 1'b1;
                r_acc  <= '0;
                r_x    <= i_cmd.x;
                r_y    <= i_cmd.y;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_y[0]) r_acc <= r_acc + r_x;
                r_x   <= r_x << 1;
                r_y   <= r_y >> 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == rau_pkg::CntBits'(rau_pkg::ResBits - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule
`default_nettype wire

// ----- rtl/core/rau_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rau_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire rau_pkg::t_div_cmd               i_cmd,
    output logic                                 o_done,
    output logic [rau_pkg::MagBits-1:0]          o_quo,
    output logic [rau_pkg::MagBits-1:0]          o_rem
);
    logic [rau_pkg::MagBits-1:0] r_q, r_d;
    logic [rau_pkg::MagBits:0]   r_r;
    logic [rau_pkg::MagBits:0]   w_sh;
    logic [rau_pkg::CntBits-1:0] r_cnt;
    logic                        r_busy, r_done;

    assign w_sh = {r_r[rau_pkg::MagBits-1:0], r_q[rau_pkg::MagBits-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && !i_cmd.go &&
                      (r_cnt == rau_pkg::CntBits'(rau_pkg::MagBits - 1));
            if (i_cmd.go) begin
                r_busy <= 1'b1;
                r_q    <= i_cmd.dividend;
                r_d    <= i_cmd.divisor;
                r_r    <= '0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (w_sh >= {1'b0, r_d}) begin
                    r_r <= w_sh - {1'b0, r_d};
                    r_q <= {r_q[rau_pkg::MagBits-2:0], 1'b1};
                end else begin
                    r_r <= w_sh;
                    r_q <= {r_q[rau_pkg::MagBits-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == rau_pkg::CntBits'(rau_pkg::MagBits - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_rem  = r_r[rau_pkg::MagBits-1:0];
endmodule
`default_nettype wire

// ----- rtl/core/rational_arithmetic_unit_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top
// Fraction add/sub/mul/div/power with GCD reduction and compare flags.
// ----------------------------------------------------------------------------
// Usage:
//  - Drive i_kind and the four operands, pulse start while busy is low.
//    The beat is taken at that edge; busy stays high until the result.
//  - The result is on o_res_* for one cycle with o_valid high. There is no
//    back pressure: the receiver must take it in that cycle.
// Sequencing: a sequencer drives one shared shift-add multiplier and one
//  restoring divider. The products come first: two compare cross products
//  plus up to six result products. Items that skip reduction raise o_valid
//  once the products are done. Reduced items add a settle pass through
//  S_OUT, the Euclid steps (up to about 66 for 46-bit values) and the two
//  exact divisions.
// Throughput: one item at a time; the next start is taken once busy falls.
// Reset: synchronous active low; the sequencer returns to idle, no result.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_top (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      start,
    output logic                                           busy,
    input  wire logic [rau_pkg::KindBits-1:0]              i_kind,
    input  wire logic signed [rau_pkg::OperandBits-1:0]    i_a_num,
    input  wire logic signed [rau_pkg::OperandBits-1:0]    i_a_den,
    input  wire logic signed [rau_pkg::OperandBits-1:0]    i_b_num,
    input  wire logic signed [rau_pkg::OperandBits-1:0]    i_b_den,
    output logic                                           o_valid,
    output logic signed [rau_pkg::ResBits-1:0]             o_res_num,
    output logic signed [rau_pkg::ResBits-1:0]             o_res_den,
    output logic                                           o_a_greater,
    output logic                                           o_a_less,
    output logic                                           o_exp_error
);
    localparam int RB = rau_pkg::ResBits;
    localparam int MB = rau_pkg::MagBits;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,  // issue one product
        S_MWT  = 8'b0000_0100,  // wait for product
        S_GCD  = 8'b0000_1000,  // issue m % n
        S_GWT  = 8'b0001_0000,
        S_QN   = 8'b0010_0000,  // issue exact divisions
        S_QWT  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state r_st;
    logic [rau_pkg::KindBits-1:0] r_kind;
    logic signed [RB-1:0] r_an, r_ad, r_bn, r_bd;
    logic signed [RB-1:0] r_lhs, r_rhs, r_rn, r_rd, r_t;
    logic [2:0]  r_step;   // product sequence index
    logic        r_second; // second exact division
    logic [MB-1:0] r_m, r_n;
    logic        r_err, r_red;
    logic [RB-1:0] r_onum, r_oden;
    logic        r_ogt, r_olt, r_oerr, r_ovalid;

    rau_pkg::t_mul_cmd w_mcmd;
    rau_pkg::t_div_cmd w_dcmd;
    logic          w_mdone, w_ddone;
    logic signed [RB-1:0] w_prod;
    logic [MB-1:0] w_quo, w_rem;

    rau_mul u_mul (.i_clk, .i_rst_n, .i_cmd(w_mcmd), .o_done(w_mdone), .o_prod(w_prod));
    rau_div u_div (.i_clk, .i_rst_n, .i_cmd(w_dcmd), .o_done(w_ddone),
                   .o_quo(w_quo), .o_rem(w_rem));

    function automatic logic [MB-1:0] f_mag(input logic signed [RB-1:0] v);
        logic [RB-1:0] a;
        a = v[RB-1] ? -v : v;
        return a[MB-1:0];
    endfunction

    logic signed [RB-1:0] w_exp;
    logic w_pow_ok;
    assign w_exp    = r_bn;
    assign w_pow_ok = !r_bn[RB-1] && (r_bn <= RB'(rau_pkg::MaxExponent));

    // Raw operand passes through: bad exponent, divide by zero numerator,
    // undefined operation code.
    logic w_skip;
    assign w_skip = (r_kind == rau_pkg::KIND_POW && !w_pow_ok) ||
                    (r_kind == rau_pkg::KIND_DIV && r_bn == '0) ||
                    (r_kind > rau_pkg::KIND_POW);

    // Product list: step 0 lhs, 1 rhs, then per kind.
    // add/sub: 2 rd=ad*bd; mul: 2 rn=an*bn,3 rd; div: 2 rn=an*bd, 3 rd=ad*bn
    // pow: steps 2.. multiply rn by an then rd by ad, b_num times.
    always_comb begin
        w_mcmd = '0;
        if (r_st == S_MUL) begin
            w_mcmd.go = 1'b1;
            unique case (r_step)
                3'd0: begin w_mcmd.x = r_an; w_mcmd.y = r_bd; end
                3'd1: begin w_mcmd.x = r_bn; w_mcmd.y = r_ad; end
                default: begin
                    if (r_kind == rau_pkg::KIND_POW) begin
                        w_mcmd.x = r_step[0] ? r_rd : r_rn;
                        w_mcmd.y = r_step[0] ? r_ad : r_an;
                    end else if (r_kind == rau_pkg::KIND_MUL && r_step == 3'd2) begin
                        w_mcmd.x = r_an; w_mcmd.y = r_bn;
                    end else if (r_kind == rau_pkg::KIND_DIV) begin
                        w_mcmd.x = (r_step == 3'd2) ? r_an : r_ad;
                        w_mcmd.y = (r_step == 3'd2) ? r_bd : r_bn;
                    end else begin
                        w_mcmd.x = r_ad; w_mcmd.y = r_bd;
                    end
                end
            endcase
        end
        w_dcmd = '0;
        if (r_st == S_GCD) begin
            w_dcmd.go = 1'b1; w_dcmd.dividend = r_m; w_dcmd.divisor = r_n;
        end else if (r_st == S_QN) begin
            w_dcmd.go = 1'b1;
            w_dcmd.dividend = r_second ? f_mag(r_rd) : f_mag(r_rn);
            w_dcmd.divisor  = r_n;
        end
    end

    // Last product step index for the current kind.
    logic [2:0] w_last;
    always_comb begin
        unique case (r_kind)
            rau_pkg::KIND_ADD, rau_pkg::KIND_SUB: w_last = 3'd2;
            rau_pkg::KIND_MUL, rau_pkg::KIND_DIV: w_last = 3'd3;
            rau_pkg::KIND_POW: w_last = 3'd1 + 3'(w_exp[1:0]) * 3'd2;
            default: w_last = 3'd1;
        endcase
    end

    logic signed [RB-1:0] w_q;
    assign w_q = RB'(w_quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= (r_st == S_OUT) && !r_red;
            unique case (r_st)
                S_IDLE: if (start) begin
                    r_kind <= i_kind;
                    r_an <= RB'(i_a_num); r_ad <= RB'(i_a_den);
                    r_bn <= RB'(i_b_num); r_bd <= RB'(i_b_den);
                    r_rn <= RB'(i_a_num); r_rd <= RB'(i_a_den);
                    r_step <= '0;
                    r_st <= S_MUL;
                end
                S_MUL: r_st <= S_MWT;
                S_MWT: if (w_mdone) begin
                    if (r_step == 3'd0) r_lhs <= w_prod;
                    else if (r_step == 3'd1) begin
                        r_rhs <= w_prod;
                        if (r_kind == rau_pkg::KIND_POW && w_pow_ok) begin
                            r_rn <= RB'(1); r_rd <= RB'(1);
                        end
                    end else if (r_kind == rau_pkg::KIND_POW) begin
                        if (r_step[0]) r_rd <= w_prod; else r_rn <= w_prod;
                    end else if (r_kind == rau_pkg::KIND_ADD ||
                                 r_kind == rau_pkg::KIND_SUB) begin
                        // raw add/sub numerator comes straight from cross products
                        r_rn <= (r_kind == rau_pkg::KIND_ADD) ?
                                r_lhs + r_rhs : r_lhs - r_rhs;
                        r_rd <= w_prod;
                    end else if (r_step == 3'd2) r_rn <= w_prod;
                    else r_rd <= w_prod;
                    if (r_step == 3'd1 && w_skip) begin
                        r_red <= 1'b0; r_st <= S_OUT;
                    end else if (r_step < w_last) begin
                        r_step <= r_step + 1'b1; r_st <= S_MUL;
                    end else begin
                        // one pass through S_OUT lets the last product settle
                        r_red <= 1'b1; r_st <= S_OUT;
                    end
                end
                S_GCD: r_st <= S_GWT;
                S_GWT: if (w_ddone) begin
                    if (w_rem == '0) begin
                        r_second <= 1'b0; r_st <= S_QN;
                    end else begin
                        r_m <= r_n; r_n <= w_rem; r_st <= S_GCD;
                    end
                end
                S_QN: r_st <= S_QWT;
                S_QWT: if (w_ddone) begin
                    if (!r_second) begin
                        r_t <= r_rn[RB-1] ? -w_q : w_q;
                        r_second <= 1'b1; r_st <= S_QN;
                    end else begin
                        if (r_rd[RB-1]) begin
                            r_rn <= -r_t; r_rd <= w_q;
                        end else begin
                            r_rn <= r_t; r_rd <= w_q;
                        end
                        r_red <= 1'b0; r_st <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (r_red) begin
                        // load the gcd loop; zero numerator skips it
                        r_red <= 1'b0;
                        if (r_rn != '0) begin
                            r_m  <= f_mag(r_rd);
                            r_n  <= f_mag(r_rn);
                            r_st <= S_GCD;
                        end
                    end else begin
                        r_onum <= r_rn; r_oden <= r_rd;
                        r_ogt  <= r_lhs > r_rhs; r_olt <= r_lhs < r_rhs;
                        r_oerr <= (r_kind == rau_pkg::KIND_POW) && !w_pow_ok;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign busy        = (r_st != S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_res_num   = r_onum;
    assign o_res_den   = r_oden;
    assign o_a_greater = r_ogt;
    assign o_a_less    = r_olt;
    assign o_exp_error = r_oerr;
endmodule
`default_nettype wire

// ----- rtl/core/rau_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "rational_arithmetic_unit_top_defines.svh"
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks on the command handshake and result beats.
// ----------------------------------------------------------------------------
module rau_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_valid,
    input wire logic o_a_greater,
    input wire logic o_a_less
);
    `RAU_ASSERT(a_take_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "busy missing after start")
    `RAU_ASSERT(a_valid_one, i_clk, i_rst_n, o_valid |=> !o_valid, "result beat longer than one cycle")
    `RAU_ASSERT(a_cmp_excl, i_clk, i_rst_n, o_valid |-> !(o_a_greater && o_a_less), "greater and less both set")
    `RAU_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> (!busy && !o_valid), "not idle after reset")
endmodule

bind rational_arithmetic_unit_top rau_checker u_rau_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_a_greater(o_a_greater), .o_a_less(o_a_less)
);
`default_nettype wire
